@@ rtl/mcc_pkg.sv @@
// Package: command codes, operation types and constants for the cover controller.
`timescale 1ns / 1ps
package mcc_pkg;

  localparam int unsigned CMD_W     = 17;
  localparam int unsigned POS_W     = 15;
  localparam int unsigned CLOSED_W  = 12;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned VOLT_W    = 12;

  localparam logic [CMD_W-1:0] CMD_CLOSE      = 17'd1000;
  localparam logic [CMD_W-1:0] CMD_OPEN       = 17'd1001;
  localparam logic [CMD_W-1:0] CMD_HEAT_0     = 17'd2000;
  localparam logic [CMD_W-1:0] CMD_HEAT_50    = 17'd2050;
  localparam logic [CMD_W-1:0] CMD_HEAT_100   = 17'd2100;
  localparam logic [CMD_W-1:0] CMD_HEAT_150   = 17'd2150;
  localparam logic [CMD_W-1:0] CMD_LIGHT_OFF  = 17'd9999;
  localparam logic [CMD_W-1:0] CMD_OPEN_LO    = 17'd40000;
  localparam logic [CMD_W-1:0] CMD_OPEN_HI    = 17'd67000;
  localparam logic [CMD_W-1:0] CMD_CLOSED_LO  = 17'd10000;
  localparam logic [CMD_W-1:0] CMD_CLOSED_HI  = 17'd12055;
  localparam logic [CMD_W-1:0] CMD_LIGHT_LO   = 17'd1;
  localparam logic [CMD_W-1:0] CMD_LIGHT_HI   = 17'd255;

  localparam logic [POS_W-1:0]    STEP_SIZE     = 15'd1500;
  localparam logic [POS_W-1:0]    OPEN_RESET    = 15'd27000;
  localparam logic [CLOSED_W-1:0] CLOSED_RESET  = 12'd2000;
  localparam logic [POS_W-1:0]    POS_RESET     = 15'd2000;
  localparam logic [VOLT_W-1:0]   VOLT_RESET    = 12'd1211;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLOSE,
    OP_OPEN,
    OP_HEATER,
    OP_LIGHT,
    OP_OPEN_TGT,
    OP_CLOSED_TGT,
    OP_TICK
  } op_code_t;

  typedef struct packed {
    op_code_t          code;
    logic [POS_W-1:0]  arg;
  } op_t;

endpackage

@@ rtl/mcc_if.sv @@
// Interfaces: command, status and configuration channels.
`timescale 1ns / 1ps
interface mcc_cmd_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [mcc_pkg::CMD_W-1:0] command_value;
  modport source (output valid, output mode, output command_value, input ready);
  modport sink   (input valid, input mode, input command_value, output ready);
endinterface

interface mcc_status_if;
  logic                         valid;
  logic                         ready;
  logic [mcc_pkg::CLOSED_W-1:0] closed_position;
  logic [mcc_pkg::POS_W-1:0]    open_position;
  logic [mcc_pkg::POS_W-1:0]    current_position;
  logic [mcc_pkg::LEVEL_W-1:0]  light_level;
  logic [mcc_pkg::LEVEL_W-1:0]  heater_level;
  logic [mcc_pkg::VOLT_W-1:0]   voltage_report;
  modport source (output valid, output closed_position, output open_position,
                  output current_position, output light_level, output heater_level,
                  output voltage_report, input ready);
  modport sink   (input valid, input closed_position, input open_position,
                  input current_position, input light_level, input heater_level,
                  input voltage_report, output ready);
endinterface

interface mcc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [mcc_pkg::VOLT_W-1:0] supply_voltage;
  modport source (output valid, output supply_voltage, input ready);
  modport sink   (input valid, input supply_voltage, output ready);
endinterface

@@ rtl/mcc_front.sv @@
// Front end: accepts items and decodes them into operations.
`timescale 1ns / 1ps
module mcc_front (
  mcc_cmd_if.sink        cmd,
  input  logic           q_full,
  output logic           push,
  output mcc_pkg::op_t   push_op
);
  import mcc_pkg::*;

  logic [CMD_W-1:0] v;
  logic [CMD_W-1:0] open_arg;
  logic [CMD_W-1:0] closed_arg;

  assign v          = cmd.command_value;
  assign open_arg   = v - CMD_OPEN_LO;
  assign closed_arg = v - CMD_CLOSED_LO;
  assign cmd.ready  = !q_full;
  assign push       = cmd.valid && !q_full && (push_op.code != OP_NONE);

  always_comb begin
    push_op.code = OP_NONE;
    push_op.arg  = '0;
    if (cmd.mode) begin
      push_op.code = OP_TICK;
    end else begin
      case (v)
        CMD_CLOSE:     push_op.code = OP_CLOSE;
        CMD_OPEN:      push_op.code = OP_OPEN;
        CMD_HEAT_0: begin
          push_op.code = OP_HEATER;
          push_op.arg  = 15'd0;
        end
        CMD_HEAT_50: begin
          push_op.code = OP_HEATER;
          push_op.arg  = 15'd50;
        end
        CMD_HEAT_100: begin
          push_op.code = OP_HEATER;
          push_op.arg  = 15'd100;
        end
        CMD_HEAT_150: begin
          push_op.code = OP_HEATER;
          push_op.arg  = 15'd150;
        end
        CMD_LIGHT_OFF: begin
          push_op.code = OP_LIGHT;
          push_op.arg  = 15'd0;
        end
        default: begin
          if (v inside {[CMD_OPEN_LO:CMD_OPEN_HI]}) begin
            push_op.code = OP_OPEN_TGT;
            push_op.arg  = open_arg[POS_W-1:0];
          end else if (v inside {[CMD_CLOSED_LO:CMD_CLOSED_HI]}) begin
            push_op.code = OP_CLOSED_TGT;
            push_op.arg  = closed_arg[POS_W-1:0];
          end else if (v inside {[CMD_LIGHT_LO:CMD_LIGHT_HI]}) begin
            push_op.code = OP_LIGHT;
            push_op.arg  = v[POS_W-1:0];
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/mcc_queue.sv @@
// Two-entry queue of decoded operations between front and back.
`timescale 1ns / 1ps
module mcc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mcc_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output mcc_pkg::op_t  q_op
);
  import mcc_pkg::*;

  op_t        mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_op    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/mcc_back.sv @@
// Back end: applies operations to the cover state and registers status items.
`timescale 1ns / 1ps
module mcc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  mcc_pkg::op_t  q_op,
  output logic          pop,
  mcc_cfg_if.sink       cfg,
  mcc_status_if.source  status
);
  import mcc_pkg::*;

  logic [POS_W-1:0]    open_target;
  logic [CLOSED_W-1:0] closed_target;
  logic [POS_W-1:0]    position_now;
  logic [LEVEL_W-1:0]  heater_setting;
  logic [LEVEL_W-1:0]  light_setting;
  logic                opening;
  logic                closing;
  logic [VOLT_W-1:0]   supply_voltage;
  logic                out_valid;

  logic                out_free;
  logic [POS_W:0]      diff_open;
  logic [POS_W:0]      diff_closed;
  logic                open_far;
  logic                closed_far;

  assign out_free     = !out_valid || status.ready;
  assign pop          = q_valid && ((q_op.code != OP_TICK) || out_free);
  assign status.valid = out_valid;
  assign cfg.ready    = 1'b1;

  assign diff_open   = {1'b0, open_target} - {1'b0, position_now};
  assign diff_closed = {1'b0, position_now} - {4'b0, closed_target};
  assign open_far    = $signed(diff_open) > $signed({1'b0, STEP_SIZE});
  assign closed_far  = $signed(diff_closed) > $signed({1'b0, STEP_SIZE});

  always_ff @(posedge clk) begin
    if (rst) begin
      supply_voltage <= VOLT_RESET;
    end else if (cfg.valid) begin
      supply_voltage <= cfg.supply_voltage;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (q_op.code == OP_TICK)) begin
      status.closed_position  <= closed_target;
      status.open_position    <= open_target;
      status.current_position <= position_now;
      status.light_level      <= light_setting;
      status.heater_level     <= heater_setting;
      status.voltage_report   <= supply_voltage;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_target    <= OPEN_RESET;
      closed_target  <= CLOSED_RESET;
      position_now   <= POS_RESET;
      heater_setting <= '0;
      light_setting  <= '0;
      opening        <= 1'b0;
      closing        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (pop && (q_op.code == OP_TICK)) begin
        out_valid <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        case (q_op.code)
          OP_CLOSE: begin
            opening <= 1'b0;
            closing <= 1'b1;
          end
          OP_OPEN: begin
            opening <= 1'b1;
            closing <= 1'b0;
          end
          OP_HEATER:     heater_setting <= q_op.arg[LEVEL_W-1:0];
          OP_LIGHT:      light_setting  <= q_op.arg[LEVEL_W-1:0];
          OP_OPEN_TGT:   open_target    <= q_op.arg;
          OP_CLOSED_TGT: closed_target  <= q_op.arg[CLOSED_W-1:0];
          OP_TICK: begin
            if (opening) begin
              if (open_far) begin
                position_now <= position_now + STEP_SIZE;
              end else begin
                position_now <= open_target;
                opening      <= 1'b0;
              end
            end else if (closing) begin
              if (closed_far) begin
                position_now <= position_now - STEP_SIZE;
              end else begin
                position_now <= {3'b0, closed_target};
                closing      <= 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/motorized_cover_controller_core.sv @@
// Top level: motorized cover controller, front decode, queue and back end.
//
//   channel  dir   payload                                   handshake
//   cmd      in    mode, command_value                       valid/ready
//   status   out   positions, light, heater, voltage         valid/ready
//   cfg      in    supply_voltage                            valid/ready (ready tied high)
//
// One item per cycle sustained while the queue has room; a tick's status item passes
// through the two-entry queue between decode and execute, then the status register.
// Synchronous reset restores all targets, settings and the supply voltage.
// A tick waiting on a stalled status output holds the queue; cmd stalls once it is full.
`timescale 1ns / 1ps
module motorized_cover_controller_core (
  input  logic          clk,
  input  logic          rst,
  mcc_cmd_if.sink       cmd,
  mcc_status_if.source  status,
  mcc_cfg_if.sink       cfg
);
  import mcc_pkg::*;

  logic q_full;
  logic push;
  op_t  push_op;
  logic pop;
  logic q_valid;
  op_t  q_op;

  mcc_front u_front (
    .cmd     (cmd),
    .q_full  (q_full),
    .push    (push),
    .push_op (push_op)
  );

  mcc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  mcc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_op    (q_op),
    .pop     (pop),
    .cfg     (cfg),
    .status  (status)
  );

endmodule

@@ tb/tb_top.sv @@
// Testbench for the cover controller: directed table, random phases, in-order status checking.
`timescale 1ns / 1ps
module tb_top;
  import mcc_pkg::*;

  localparam int LIMIT = 400000;
  localparam int PHASE_ITEMS = 350;
  localparam int PHASES = 5;

  typedef struct packed {
    logic [CLOSED_W-1:0] closed_position;
    logic [POS_W-1:0]    open_position;
    logic [POS_W-1:0]    current_position;
    logic [LEVEL_W-1:0]  light_level;
    logic [LEVEL_W-1:0]  heater_level;
    logic [VOLT_W-1:0]   voltage_report;
  } status_t;

  typedef struct packed {
    logic             mode;
    logic [CMD_W-1:0] value;
    logic             pinned;
    status_t          want;
  } row_t;

  localparam status_t NO_STATUS = '0;
  localparam logic [CMD_W-1:0] ALL_ONES = '1;

  localparam row_t PLAN [26] = '{
    '{1'b1, 17'd0, 1'b1, '{12'd2000, 15'd27000, 15'd2000, 8'd0, 8'd0, 12'd1211}},
    '{1'b0, 17'd0, 1'b0, NO_STATUS},
    '{1'b0, CMD_LIGHT_HI, 1'b0, NO_STATUS},
    '{1'b0, CMD_LIGHT_LO, 1'b0, NO_STATUS},
    '{1'b0, CMD_HEAT_150, 1'b0, NO_STATUS},
    '{1'b1, 17'd0, 1'b1, '{12'd2000, 15'd27000, 15'd2000, 8'd1, 8'd150, 12'd1211}},
    '{1'b0, CMD_LIGHT_OFF, 1'b0, NO_STATUS},
    '{1'b0, CMD_HEAT_50, 1'b0, NO_STATUS},
    '{1'b0, CMD_HEAT_100, 1'b0, NO_STATUS},
    '{1'b0, CMD_HEAT_0, 1'b0, NO_STATUS},
    '{1'b0, CMD_LIGHT_HI + 17'd1, 1'b0, NO_STATUS},
    '{1'b0, CMD_OPEN_LO, 1'b0, NO_STATUS},
    '{1'b0, CMD_CLOSED_HI, 1'b0, NO_STATUS},
    '{1'b0, CMD_OPEN, 1'b0, NO_STATUS},
    '{1'b1, 17'd0, 1'b1, '{12'd2055, 15'd0, 15'd2000, 8'd0, 8'd0, 12'd1211}},
    '{1'b1, ALL_ONES, 1'b1, '{12'd2055, 15'd0, 15'd0, 8'd0, 8'd0, 12'd1211}},
    '{1'b0, CMD_OPEN_HI, 1'b0, NO_STATUS},
    '{1'b0, CMD_OPEN_LO - 17'd1, 1'b0, NO_STATUS},
    '{1'b0, CMD_OPEN, 1'b0, NO_STATUS},
    '{1'b1, 17'd0, 1'b0, NO_STATUS},
    '{1'b0, CMD_CLOSE, 1'b0, NO_STATUS},
    '{1'b1, 17'd0, 1'b0, NO_STATUS},
    '{1'b0, ALL_ONES, 1'b0, NO_STATUS},
    '{1'b0, CMD_CLOSED_LO, 1'b0, NO_STATUS},
    '{1'b0, CMD_CLOSED_HI + 17'd1, 1'b0, NO_STATUS},
    '{1'b1, 17'd0, 1'b0, NO_STATUS}
  };

  localparam logic [CMD_W-1:0] HEAT_CODES [4] = '{CMD_HEAT_0, CMD_HEAT_50, CMD_HEAT_100,
                                                  CMD_HEAT_150};
  localparam logic [CMD_W-1:0] ODD_CODES [8] = '{17'd0, CMD_LIGHT_HI + 17'd1,
                                                 CMD_CLOSED_LO - 17'd1, CMD_CLOSED_HI + 17'd1,
                                                 CMD_OPEN_LO - 17'd1, CMD_OPEN_HI + 17'd1,
                                                 CMD_OPEN + 17'd1, ALL_ONES};

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  mcc_cmd_if    cmd_ch();
  mcc_status_if st_ch();
  mcc_cfg_if    cfg_ch();

  motorized_cover_controller_core u_top (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .status (st_ch),
    .cfg    (cfg_ch)
  );

  logic [VOLT_W-1:0]   volt_now;
  logic [POS_W-1:0]    open_tgt;
  logic [CLOSED_W-1:0] closed_tgt;
  logic [POS_W-1:0]    cover_pos;
  logic [LEVEL_W-1:0]  heat_now;
  logic [LEVEL_W-1:0]  light_now;
  bit                  opening;
  bit                  closing;

  status_t pending_status [$];
  logic    pin_en;
  status_t pin_val;

  int errors = 0;
  int cycles = 0;
  int items_in = 0;
  int ticks_in = 0;
  int status_checked = 0;
  int volt_writes = 0;
  int src_pct = 0;
  int sink_pct = 0;
  int stall_left = 0;

  function automatic bit step_cover(input logic m, input logic [CMD_W-1:0] v,
                                    output status_t st);
    int cur;
    int tgt;
    st = '0;
    if (!m) begin
      case (v)
        CMD_CLOSE:     begin opening = 1'b0; closing = 1'b1; end
        CMD_OPEN:      begin opening = 1'b1; closing = 1'b0; end
        CMD_HEAT_0:    heat_now = 8'd0;
        CMD_HEAT_50:   heat_now = 8'd50;
        CMD_HEAT_100:  heat_now = 8'd100;
        CMD_HEAT_150:  heat_now = 8'd150;
        CMD_LIGHT_OFF: light_now = 8'd0;
        default: begin
          if (v >= CMD_OPEN_LO && v <= CMD_OPEN_HI)
            open_tgt = POS_W'(v - CMD_OPEN_LO);
          else if (v >= CMD_CLOSED_LO && v <= CMD_CLOSED_HI)
            closed_tgt = CLOSED_W'(v - CMD_CLOSED_LO);
          else if (v >= CMD_LIGHT_LO && v <= CMD_LIGHT_HI)
            light_now = v[LEVEL_W-1:0];
        end
      endcase
      return 1'b0;
    end
    st.closed_position  = closed_tgt;
    st.open_position    = open_tgt;
    st.current_position = cover_pos;
    st.light_level      = light_now;
    st.heater_level     = heat_now;
    st.voltage_report   = volt_now;
    cur = int'(cover_pos);
    if (opening) begin
      tgt = int'(open_tgt);
      if (tgt - cur > int'(STEP_SIZE)) begin
        cur += int'(STEP_SIZE);
      end else begin
        cur = tgt;
        opening = 1'b0;
      end
    end else if (closing) begin
      tgt = int'(closed_tgt);
      if (cur - tgt > int'(STEP_SIZE)) begin
        cur -= int'(STEP_SIZE);
      end else begin
        cur = tgt;
        closing = 1'b0;
      end
    end
    cover_pos = POS_W'(cur);
    return 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    status_t pred;
    status_t want;
    if (rst) begin
      volt_now   = VOLT_RESET;
      open_tgt   = OPEN_RESET;
      closed_tgt = CLOSED_RESET;
      cover_pos  = POS_RESET;
      heat_now   = '0;
      light_now  = '0;
      opening    = 1'b0;
      closing    = 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        volt_now = cfg_ch.supply_voltage;
        volt_writes++;
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        items_in++;
        if (step_cover(cmd_ch.mode, cmd_ch.command_value, pred)) begin
          ticks_in++;
          pending_status.push_back(pin_en ? pin_val : pred);
        end
      end
      if (st_ch.valid && st_ch.ready) begin
        if (pending_status.size() == 0) begin
          $error("status item with none expected");
          errors++;
        end else begin
          want = pending_status.pop_front();
          check_field("closed_position", want.closed_position, st_ch.closed_position);
          check_field("open_position", want.open_position, st_ch.open_position);
          check_field("current_position", want.current_position, st_ch.current_position);
          check_field("light_level", want.light_level, st_ch.light_level);
          check_field("heater_level", want.heater_level, st_ch.heater_level);
          check_field("voltage_report", want.voltage_report, st_ch.voltage_report);
          status_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      st_ch.ready <= 1'b0;
    end else if (sink_pct > 0 && $urandom_range(0, 99) < sink_pct) begin
      stall_left <= $urandom_range(0, 13);
      st_ch.ready <= 1'b0;
    end else begin
      st_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic m, input logic [CMD_W-1:0] v, input logic pin,
                           input status_t pv);
    if (src_pct > 0 && $urandom_range(0, 99) < src_pct) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.mode          <= m;
    cmd_ch.command_value <= v;
    pin_en               <= pin;
    pin_val              <= pv;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_voltage(input logic [VOLT_W-1:0] v);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.supply_voltage <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [VOLT_W-1:0] volts [PHASES];
    logic [CMD_W-1:0]  v;
    logic              m;
    int                counted;
    cmd_ch.valid          = 1'b0;
    cmd_ch.mode           = 1'b0;
    cmd_ch.command_value  = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.supply_voltage = '0;
    st_ch.ready           = 1'b0;
    pin_en                = 1'b0;
    pin_val               = '0;
    volts = '{12'd0, 12'd2550, 12'hFFF, VOLT_W'($urandom_range(0, 2550)),
              VOLT_W'($urandom_range(0, 2550))};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i])
      send_item(PLAN[i].mode, PLAN[i].value, PLAN[i].pinned, PLAN[i].want);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_voltage(volts[p]);
      case (p)
        0:       begin src_pct = 20; sink_pct = 20; end
        2:       begin src_pct = 50; sink_pct = 10; end
        3:       begin src_pct = 10; sink_pct = 50; end
        default: begin src_pct = 0;  sink_pct = 0;  end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        m = 1'b0;
        counted++;
        if ($urandom_range(0, 99) < 30) begin
          m = 1'b1;
          v = CMD_W'($urandom);
        end else begin
          case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 1) ? CMD_OPEN : CMD_CLOSE;
            1: v = HEAT_CODES[$urandom_range(0, 3)];
            2: v = CMD_LIGHT_OFF;
            3: v = CMD_W'($urandom_range(1, 255));
            4, 5: v = CMD_OPEN_LO + CMD_W'($urandom_range(0, 27000));
            6: v = CMD_CLOSED_LO + CMD_W'($urandom_range(0, 2055));
            7: v = ODD_CODES[$urandom_range(0, 7)];
            default: v = CMD_W'($urandom);
          endcase
        end
        send_item(m, v, 1'b0, NO_STATUS);
      end
      drain();
    end

    $display("Sent %0d items (%0d ticks), checked %0d status items.",
             items_in, ticks_in, status_checked);
    $display("Supply voltage written %0d times, including 0, 2550 and all ones.", volt_writes);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
